>>> rtl/ad_pkg.sv
// Package for the arithmetic derivative unit: widths, reset value and modulus limit.
// No dependencies.
`timescale 1ns / 1ps
package ad_pkg;
	localparam int NumberWidthDefault = 32;
	localparam int DerivWidth = 37;
	localparam int ModWidth = 9;
	localparam int ResWidth = 8;
	localparam logic [8:0] ModReset = 9'd2;
	localparam logic [8:0] ModMax = 9'd256;
endpackage

>>> rtl/arithmetic_derivative_unit.sv
// Arithmetic derivative unit top level: sequencer, shared divider, residue step.
// Depends on ad_pkg and ad_divider.
// Each trial divisor takes a square compare and a division; each factor found takes
// another division for n/p; a residue reduction and an output state follow.
// Throughput: one request at a time; ready only while idle.
// Reset: arst_n clears control state and sets the residue modulus mod_q to 2.
`timescale 1ns / 1ps
module arithmetic_derivative_unit #(
	parameter int NUMBER_WIDTH = ad_pkg::NumberWidthDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [8:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] number_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [36:0] derivative,
	output logic [7:0]  residue
);
	localparam int W = NUMBER_WIDTH;
	localparam int DW = ad_pkg::DerivWidth;
	localparam int RCW = $clog2(DW + 1);
	localparam logic [3:0] S_IDLE = 4'd0, S_TEST = 4'd1, S_WTEST = 4'd2,
		S_SQ = 4'd3, S_WSTRIP = 4'd4, S_WADD = 4'd5, S_LEFT = 4'd6,
		S_WLEFT = 4'd7, S_RES = 4'd8, S_OUT = 4'd9;

	logic [3:0]    st_q;
	logic [8:0]    mod_q;
	logic [W-1:0]  whole_q, rest_q, d_q, q_hold_q;
	logic [DW-1:0] sum_q;
	logic [8:0]    rr_q;
	logic [RCW-1:0] rc_q;
	logic [7:0]    res_q;
	logic          dv_start, dv_done;
	logic [W-1:0]  dv_a, dv_b, dv_quo, dv_rem;
	logic [2*W-1:0] dsq;
	logic [8:0]    meff;
	logic [9:0]    rtry;

	ad_divider #(.W(W)) u_div (
		.clk(clk), .arst_n(arst_n), .start(dv_start), .dividend(dv_a),
		.divisor(dv_b), .done(dv_done), .quotient(dv_quo), .remainder(dv_rem)
	);

	// pick divider operands by state
	always_comb begin
		dv_start = 1'b0;
		dv_a = rest_q;
		dv_b = d_q;
		case (st_q)
			S_TEST: dv_start = 1'b1;
			S_SQ:   dv_start = 1'b0;
			S_WSTRIP: begin
				dv_start = 1'b1;
				dv_a = whole_q;
				dv_b = d_q;
			end
			S_LEFT: begin
				dv_start = 1'b1;
				dv_a = whole_q;
				dv_b = rest_q;
			end
			default: dv_start = 1'b0;
		endcase
	end

	assign dsq = d_q * d_q;
	assign meff = (mod_q > ad_pkg::ModMax) ? ad_pkg::ModMax : mod_q;
	assign rtry = {rr_q, sum_q[rc_q - 1'b1]} - {1'b0, meff};

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) mod_q <= ad_pkg::ModReset;
		else if (cfg_we) mod_q <= cfg_wdata;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
		end else begin
			case (st_q)
				S_IDLE: if (in_valid) begin
					st_q <= (number_in[W-1:0] < W'(2)) ? S_RES : S_SQ;
				end
				S_SQ: st_q <= (dsq > {{W{1'b0}}, rest_q}) ? S_LEFT : S_TEST;
				S_TEST: st_q <= S_WTEST;
				S_WTEST: if (dv_done) begin
					st_q <= (dv_rem == '0) ? S_WSTRIP : S_SQ;
				end
				S_WSTRIP: st_q <= S_WADD;
				S_WADD: if (dv_done) st_q <= S_TEST;
				S_LEFT: st_q <= (rest_q > W'(1)) ? S_WLEFT : S_RES;
				S_WLEFT: if (dv_done) st_q <= S_RES;
				S_RES: if (rc_q == '0) st_q <= S_OUT;
				S_OUT: if (out_ready) st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// datapath: factor bookkeeping and sum
	always_ff @(posedge clk) begin
		case (st_q)
			S_IDLE: begin
				whole_q <= number_in[W-1:0];
				rest_q <= number_in[W-1:0];
				d_q <= W'(2);
				sum_q <= '0;
				q_hold_q <= '0;
				rr_q <= '0;
				rc_q <= RCW'(DW);
			end
			S_WTEST: if (dv_done) begin
				if (dv_rem == '0) begin
					q_hold_q <= dv_quo;
				end else begin
					d_q <= d_q + 1'b1;
				end
			end
			// divide the factor out, then add whole/d by a second division
			S_WSTRIP: rest_q <= q_hold_q;
			S_WADD: if (dv_done) sum_q <= sum_q + DW'(dv_quo);
			S_WLEFT: if (dv_done) sum_q <= sum_q + DW'(dv_quo);
			S_RES: if (rc_q != '0) begin
				if (meff == '0) begin
					rr_q <= '0;
				end else if (!rtry[9]) begin
					rr_q <= rtry[8:0];
				end else begin
					rr_q <= {rr_q[7:0], sum_q[rc_q - 1'b1]};
				end
				rc_q <= rc_q - 1'b1;
			end else begin
				res_q <= rr_q[7:0];
			end
			default: ;
		endcase
	end

	assign in_ready = (st_q == S_IDLE);
	assign out_valid = (st_q == S_OUT);
	assign derivative = sum_q;
	assign residue = res_q;
endmodule

>>> rtl/ad_divider.sv
// Restoring divider for the arithmetic derivative unit: one quotient bit per cycle.
// Depends on nothing outside this file.
`timescale 1ns / 1ps
module ad_divider #(
	parameter int W = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         done,
	output logic [W-1:0] quotient,
	output logic [W-1:0] remainder
);
	localparam int CW = $clog2(W + 1);
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [W-1:0]  quo_q;
	logic [W:0]    rem_q;
	logic [W-1:0]  dsr_q;
	logic [W:0]    trial;
	logic [W:0]    shifted;

	// shift in the next dividend bit and try a subtract
	assign shifted = {rem_q[W-1:0], quo_q[W-1]};
	assign trial = shifted - {1'b0, dsr_q};

	// step the division
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			if (!trial[W]) begin
				rem_q <= trial;
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign quotient = quo_q;
	assign remainder = rem_q[W-1:0];
endmodule
